@@ rtl/bpfa_pkg.sv @@
// shared constants, codes and helpers of the bitmap page frame allocator
`default_nettype none

package bpfa_pkg;

   localparam int NUM_PAGES_DEF = 65536;
   localparam int WORD_BITS     = 32;
   localparam int BIT_W         = 5;
   localparam int PAGE_W        = 16;
   localparam int SCAN_WORD_W   = PAGE_W - BIT_W;
   localparam int COUNT_W       = 17;
   localparam int KIND_W        = 3;
   localparam int SCAN_PAGES    = 65536;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(SCAN_PAGES);

   typedef enum logic [KIND_W-1:0] {
      KIND_REQUEST   = 3'd0,
      KIND_FREE      = 3'd1,
      KIND_LOCK      = 3'd2,
      KIND_RESERVE   = 3'd3,
      KIND_UNRESERVE = 3'd4
   } kind_type;

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
      return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
   endfunction

   function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c);
      return (c != '0) ? c - 1'b1 : '0;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bitmap_page_frame_allocator.sv @@
// bitmap page frame allocator: busy bitmap in ram, search hint and page counters
// free, lock, reserve, unreserve: the bitmap word is read, then checked and written back
// a request reads the bitmap word by word from the search hint until it finds a clear bit
// a new request is taken only once the last one has finished and its result is loaded
// reset: synchronous; a clearing pass writes zero to every word (2048 by default)
// of the bitmap ram while req_ready stays low
`default_nettype none

module bitmap_page_frame_allocator #(
   parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bpfa_pkg::COUNT_W-1:0]   csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bpfa_pkg::KIND_W-1:0]    req_kind,
   input  logic [bpfa_pkg::PAGE_W-1:0]    req_page_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_granted,
   output logic [bpfa_pkg::PAGE_W-1:0]    rsp_result_page,
   output logic                           rsp_changed,
   output logic [bpfa_pkg::COUNT_W-1:0]   rsp_free_pages,
   output logic [bpfa_pkg::COUNT_W-1:0]   rsp_used_pages,
   output logic [bpfa_pkg::COUNT_W-1:0]   rsp_reserved_pages
);

   import bpfa_pkg::*;

   localparam int WORDS      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = $clog2(WORDS);
   localparam int SCAN_LIMIT = (NUM_PAGES < SCAN_PAGES) ? NUM_PAGES : SCAN_PAGES;
   localparam int LAST_WORD  = (SCAN_LIMIT - 1) / WORD_BITS;
   localparam int LAST_BITS  = SCAN_LIMIT - LAST_WORD * WORD_BITS;

   localparam logic [COUNT_W-1:0]     SCAN_END       = COUNT_W'(SCAN_LIMIT);
   localparam logic [SCAN_WORD_W-1:0] LAST_SCAN_WORD = SCAN_WORD_W'(LAST_WORD);
   localparam logic [ADDR_W-1:0]      LAST_ADDR      = ADDR_W'(WORDS - 1);
   localparam logic [WORD_BITS-1:0]   LAST_MASK      = (LAST_BITS == WORD_BITS) ? '1 :
      WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clear_cnt_ff, clear_cnt_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [SCAN_WORD_W-1:0]  word_ff, word_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    exhausted_ff, exhausted_in;
   logic                    idx_ok_ff, idx_ok_in;
   logic [COUNT_W-1:0]      hint_ff, hint_in;
   logic [COUNT_W-1:0]      used_ff, used_in;
   logic [COUNT_W-1:0]      reserved_ff, reserved_in;
   logic [COUNT_W-1:0]      mem_pages_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_granted_ff;
   logic [PAGE_W-1:0]       rsp_page_ff;
   logic                    rsp_changed_ff;
   logic [COUNT_W-1:0]      rsp_free_ff;
   logic [COUNT_W-1:0]      rsp_used_ff;
   logic [COUNT_W-1:0]      rsp_reserved_ff;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [WORD_BITS-1:0]    ram_wr_data;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [WORD_BITS-1:0]    ram_rd_data;

   logic                    out_free;
   logic                    load;
   logic                    res_granted;
   logic [PAGE_W-1:0]       res_page;
   logic                    res_changed;
   logic [COUNT_W-1:0]      res_free;
   logic [COUNT_W:0]        taken;
   logic [WORD_BITS-1:0]    cand;
   logic                    found;
   logic [BIT_W-1:0]        pos;
   logic [WORD_BITS-1:0]    bit_sel;
   logic [WORD_BITS-1:0]    pos_sel;
   logic                    cur_bit;

   bpfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // first clear bit at or above the start bit, inside the scan range
   assign cand = ~ram_rd_data & ('1 << bit_ff)
               & ((word_ff == LAST_SCAN_WORD) ? LAST_MASK : '1)
               & {WORD_BITS{~exhausted_ff}};
   assign found = |cand;

   always_comb begin
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            pos = BIT_W'(b);
         end
      end
   end

   assign bit_sel  = WORD_BITS'(1) << bit_ff;
   assign pos_sel  = WORD_BITS'(1) << pos;
   assign cur_bit  = ram_rd_data[bit_ff];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      kind_in      = kind_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      exhausted_in = exhausted_ff;
      idx_ok_in    = idx_ok_ff;
      hint_in      = hint_ff;
      used_in      = used_ff;
      reserved_in  = reserved_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_W'(word_ff);
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_W'(word_ff);
      load         = 1'b0;
      res_granted  = 1'b0;
      res_page     = '0;
      res_changed  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_cnt_ff;
            if (clear_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clear_cnt_in = clear_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               if (req_kind == KIND_REQUEST) begin
                  word_in      = hint_ff[PAGE_W-1:BIT_W];
                  bit_in       = hint_ff[BIT_W-1:0];
                  exhausted_in = (hint_ff >= SCAN_END);
               end else begin
                  word_in      = req_page_index[PAGE_W-1:BIT_W];
                  bit_in       = req_page_index[BIT_W-1:0];
                  exhausted_in = 1'b0;
               end
               idx_ok_in   = (32'(req_page_index) < NUM_PAGES);
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(word_in);
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            case (kind_ff)
               KIND_REQUEST: begin
                  if (found) begin
                     if (out_free) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | pos_sel;
                        hint_in     = {1'b0, word_ff, pos};
                        used_in     = count_up(used_ff);
                        res_granted = 1'b1;
                        res_page    = {word_ff, pos};
                        res_changed = 1'b1;
                        load        = 1'b1;
                        state_in    = ST_IDLE;
                     end
                  end else if (exhausted_ff || word_ff == LAST_SCAN_WORD) begin
                     if (out_free) begin
                        hint_in  = SCAN_END;
                        load     = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     word_in     = word_ff + 1'b1;
                     bit_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(word_in);
                  end
               end
               KIND_FREE, KIND_UNRESERVE: begin
                  if (out_free) begin
                     load     = 1'b1;
                     state_in = ST_IDLE;
                     if (idx_ok_ff && cur_bit) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data & ~bit_sel;
                        res_changed = 1'b1;
                        if (kind_ff == KIND_FREE) begin
                           used_in = count_down(used_ff);
                        end else begin
                           reserved_in = count_down(reserved_ff);
                        end
                        if (hint_ff > {1'b0, word_ff, bit_ff}) begin
                           hint_in = {1'b0, word_ff, bit_ff};
                        end
                     end
                  end
               end
               KIND_LOCK, KIND_RESERVE: begin
                  if (out_free) begin
                     load     = 1'b1;
                     state_in = ST_IDLE;
                     if (idx_ok_ff && !cur_bit) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | bit_sel;
                        res_changed = 1'b1;
                        if (kind_ff == KIND_LOCK) begin
                           used_in = count_up(used_ff);
                        end else begin
                           reserved_in = count_up(reserved_ff);
                        end
                     end
                  end
               end
               default: begin
                  if (out_free) begin
                     load     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // free count from the updated counters, saturating at zero
   assign taken    = {1'b0, used_in} + {1'b0, reserved_in};
   assign res_free = ({1'b0, mem_pages_ff} > taken) ?
                     COUNT_W'({1'b0, mem_pages_ff} - taken) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         hint_ff      <= '0;
         used_ff      <= '0;
         reserved_ff  <= '0;
         mem_pages_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         hint_ff      <= hint_in;
         used_ff      <= used_in;
         reserved_ff  <= reserved_in;
         if (csr_wr_en) begin
            mem_pages_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      word_ff      <= word_in;
      bit_ff       <= bit_in;
      exhausted_ff <= exhausted_in;
      idx_ok_ff    <= idx_ok_in;
      if (load) begin
         rsp_granted_ff  <= res_granted;
         rsp_page_ff     <= res_page;
         rsp_changed_ff  <= res_changed;
         rsp_free_ff     <= res_free;
         rsp_used_ff     <= used_in;
         rsp_reserved_ff <= reserved_in;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_result_page    = rsp_page_ff;
   assign rsp_changed        = rsp_changed_ff;
   assign rsp_free_pages     = rsp_free_ff;
   assign rsp_used_pages     = rsp_used_ff;
   assign rsp_reserved_pages = rsp_reserved_ff;

endmodule

`default_nettype wire

@@ rtl/bpfa_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module bpfa_ram #(
   parameter int WIDTH = bpfa_pkg::WORD_BITS,
   parameter int DEPTH = bpfa_pkg::NUM_PAGES_DEF / bpfa_pkg::WORD_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/bpfa_checker.sv @@
// port-level checks of the bitmap page frame allocator and their binding
`default_nettype none

module bpfa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_granted,
   input logic [bpfa_pkg::PAGE_W-1:0]  rsp_result_page,
   input logic                         rsp_changed,
   input logic [bpfa_pkg::COUNT_W-1:0] rsp_used_pages
);

   import bpfa_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_page)
         && $stable(rsp_granted) && $stable(rsp_changed))
      else $error("stalled result changed");

   // a granted page always flips a bit and counts as used
   a_grant_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_changed && rsp_used_pages != '0)
      else $error("grant without bitmap change");

   a_nogrant_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_result_page == '0)
      else $error("page reported without grant");

   // the clearing pass keeps the input closed right after reset
   a_clear_pass: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("input open during clearing pass");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_granted     (rsp_granted),
   .rsp_result_page (rsp_result_page),
   .rsp_changed     (rsp_changed),
   .rsp_used_pages  (rsp_used_pages)
);

`default_nettype wire
